[src/fvn_pkg.sv]
// shared types and constants of the fractal value noise pixel block
package fvn_pkg;

  // datapath width of the shared shift-add/subtract unit
  localparam int XW = 64;
  // dividend bits walked by a division (largest dividend is 2^48)
  localparam int DIV_BITS = 49;
  localparam logic [XW-1:0] DIV_MASK = (64'd1 << DIV_BITS) - 64'd1;
  localparam int DIV_CNT_W = $clog2(DIV_BITS + 1);

  // frequency is unsigned q1.40, at most 1.0
  localparam int FREQ_FRAC = 40;
  localparam int FREQ_W = FREQ_FRAC + 1;
  localparam logic [XW-1:0] FREQ_ONE = 64'd1 << FREQ_FRAC;
  localparam logic [XW-1:0] FREQ_DIVIDEND = 64'd1 << 48;

  // parameter defaults
  localparam int MAX_DIM_DEF = 64;
  localparam int MAX_OCTAVES_DEF = 8;
  localparam int COS_TABLE_DEPTH_DEF = 256;

  // configuration register indexes
  localparam logic [2:0] CFG_OCTAVE_TOTAL = 3'd0;
  localparam logic [2:0] CFG_BASE_PERIOD = 3'd1;
  localparam logic [2:0] CFG_OCTAVE_GAIN = 3'd2;
  localparam logic [2:0] CFG_FREQ_STEP = 3'd3;
  localparam logic [2:0] CFG_MAP_WIDTH = 3'd4;
  localparam logic [2:0] CFG_MAP_HEIGHT = 3'd5;

  // register reset values
  localparam logic [3:0] RST_OCTAVE_TOTAL = 4'd4;
  localparam logic [15:0] RST_BASE_PERIOD = 16'd256;
  localparam logic [15:0] RST_OCTAVE_GAIN = 16'd32768;
  localparam logic [15:0] RST_FREQ_STEP = 16'd8192;
  localparam logic [6:0] RST_MAP_WIDTH = 7'd64;
  localparam logic [6:0] RST_MAP_HEIGHT = 7'd64;

  // request to the shared arithmetic unit
  typedef struct packed {
    logic start;
    logic is_div;
  } alu_req_t;

endpackage

[src/fractal_value_noise_pixel.sv]
// top level: fractal value noise pixel, sequencer around one shared arithmetic unit
//
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+------------------------------
//  command  | in_op, in_pos_x, in_pos_y, in_sample_value    | beat taken when start & !busy
//  result   | out_noise_value                               | out_valid, one cycle, no stall
//  config   | cfg_index, cfg_data                           | beat taken when cfg_valid & cfg_ready
//
// a write wraps each coordinate beyond the storage by taking MAX_DIM off until it is in
// range; a query runs all arithmetic of every octave through the shared unit, where a
// division walks 49 dividend bits and a multiply steps through its multiplier bits
// busy is high after an accepted beat until the command is done; for a query it falls
// as the result strobe rises, and the next command may start in the strobe cycle
// rst_n is synchronous; the base map is not cleared and holds garbage until written
module fractal_value_noise_pixel import fvn_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF,
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF,
  parameter int COS_TABLE_DEPTH = COS_TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [5:0]  in_pos_x,
  input  logic [5:0]  in_pos_y,
  input  logic [15:0] in_sample_value,
  output logic        out_valid,
  output logic [15:0] out_noise_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW   = $clog2(MAX_DIM);
  localparam int DW   = $clog2(MAX_DIM + 1);
  localparam int AW   = $clog2(MAX_DIM * MAX_DIM);
  localparam int OW   = $clog2(MAX_OCTAVES + 1);
  localparam int IXW  = $clog2(COS_TABLE_DEPTH + 1);
  localparam int TOTW = 16 + OW;
  localparam int SUMW = 32 + OW;

  // sequencer states
  localparam logic [5:0] S_IDLE = 6'd0;
  localparam logic [5:0] S_WMX  = 6'd1;
  localparam logic [5:0] S_WMY  = 6'd2;
  localparam logic [5:0] S_WWR  = 6'd3;
  localparam logic [5:0] S_QMX  = 6'd4;
  localparam logic [5:0] S_QMY  = 6'd5;
  localparam logic [5:0] S_INIT = 6'd6;
  localparam logic [5:0] S_F0   = 6'd7;
  localparam logic [5:0] S_LOOP = 6'd8;
  localparam logic [5:0] S_P    = 6'd9;
  localparam logic [5:0] S_RY   = 6'd10;
  localparam logic [5:0] S_Y1   = 6'd11;
  localparam logic [5:0] S_RX   = 6'd12;
  localparam logic [5:0] S_X1   = 6'd13;
  localparam logic [5:0] S_BX   = 6'd14;
  localparam logic [5:0] S_IX   = 6'd15;
  localparam logic [5:0] S_BY   = 6'd16;
  localparam logic [5:0] S_IY   = 6'd17;
  localparam logic [5:0] S_RA   = 6'd18;
  localparam logic [5:0] S_RB   = 6'd19;
  localparam logic [5:0] S_RC   = 6'd20;
  localparam logic [5:0] S_RD   = 6'd21;
  localparam logic [5:0] S_RE   = 6'd22;
  localparam logic [5:0] S_T1   = 6'd23;
  localparam logic [5:0] S_T2   = 6'd24;
  localparam logic [5:0] S_B1   = 6'd25;
  localparam logic [5:0] S_B2   = 6'd26;
  localparam logic [5:0] S_V1   = 6'd27;
  localparam logic [5:0] S_V2   = 6'd28;
  localparam logic [5:0] S_S    = 6'd29;
  localparam logic [5:0] S_F    = 6'd30;
  localparam logic [5:0] S_A    = 6'd31;
  localparam logic [5:0] S_FIN  = 6'd32;
  localparam logic [5:0] S_DIV  = 6'd33;

  // cosine blend weights, q0.16 with 1.0 allowed
  typedef logic [16:0] wtab_t [0:COS_TABLE_DEPTH];

  function automatic wtab_t build_wtab();
    wtab_t tab;
    longint unsigned t, t2, inner, mid, s, w;
    for (int i = 0; i <= COS_TABLE_DEPTH; i++) begin
      t     = (longint'(i) * 65536) / COS_TABLE_DEPTH;
      t2    = (t * t) >> 16;
      inner = 42334 - ((t2 * 5223) >> 16);
      mid   = 102944 - ((t2 * inner) >> 16);
      s     = (t * mid) >> 16;
      if (s > 65536) s = 65536;
      w = (s * s) >> 16;
      if (w > 65536) w = 65536;
      tab[i] = 17'(w);
    end
    return tab;
  endfunction

  localparam wtab_t WTAB = build_wtab();

  // configuration registers
  logic [3:0]  octave_total_r;
  logic [15:0] base_period_r;
  logic [15:0] octave_gain_r;
  logic [15:0] freq_step_r;
  logic [6:0]  map_width_r;
  logic [6:0]  map_height_r;

  // sequencer and working registers
  logic [5:0]        state_r, state_nxt;
  logic              issued_r, issued_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [15:0]       out_noise_r, out_noise_nxt;
  logic [5:0]        px_r, px_nxt;
  logic [5:0]        py_r, py_nxt;
  logic [15:0]       smp_r, smp_nxt;
  logic [CW-1:0]     x_r, x_nxt;
  logic [CW-1:0]     y_r, y_nxt;
  logic [CW-1:0]     rx_r, rx_nxt;
  logic [CW-1:0]     ry_r, ry_nxt;
  logic [CW-1:0]     x1_r, x1_nxt;
  logic [CW-1:0]     y1_r, y1_nxt;
  logic [FREQ_W-1:0] freq_r, freq_nxt;
  logic [FREQ_W-1:0] p_r, p_nxt;
  logic [FREQ_W-1:0] blend_r, blend_nxt;
  logic [IXW-1:0]    ix_r, ix_nxt;
  logic [IXW-1:0]    iy_r, iy_nxt;
  logic [15:0]       amp_r, amp_nxt;
  logic [SUMW-1:0]   sum_r, sum_nxt;
  logic [TOTW-1:0]   total_r, total_nxt;
  logic [OW-1:0]     k_r, k_nxt;
  logic [15:0]       a00_r, a00_nxt;
  logic [15:0]       a10_r, a10_nxt;
  logic [15:0]       a01_r, a01_nxt;
  logic [15:0]       a11_r, a11_nxt;
  logic [32:0]       tmp_r, tmp_nxt;
  logic [15:0]       top_r, top_nxt;
  logic [15:0]       bot_r, bot_nxt;
  logic [15:0]       v_r, v_nxt;

  // derived control values
  logic [DW-1:0]  w_c, h_c;
  logic [OW-1:0]  oct_c;
  logic [XW-1:0]  denom_c;
  logic [CW-1:0]  x0_c, y0_c;
  logic [16:0]    wx_c, wy_c;
  logic [XW-1:0]  idx_full;
  logic [IXW-1:0] idx_c;
  logic [33:0]    interp_sum;

  // shared unit
  alu_req_t      alu_req;
  logic [XW-1:0] alu_a, alu_b;
  logic          alu_done;
  logic [XW-1:0] alu_q, alu_rem;
  logic          alu_state;

  // base map
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_rdata;

  fvn_alu u_alu (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (alu_req),
    .opa      (alu_a),
    .opb      (alu_b),
    .done     (alu_done),
    .quo_prod (alu_q),
    .rem      (alu_rem)
  );

  fvn_ram #(
    .WIDTH (16),
    .DEPTH (MAX_DIM * MAX_DIM)
  ) u_base_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (smp_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // config port never stalls
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_total_r <= RST_OCTAVE_TOTAL;
      base_period_r  <= RST_BASE_PERIOD;
      octave_gain_r  <= RST_OCTAVE_GAIN;
      freq_step_r    <= RST_FREQ_STEP;
      map_width_r    <= RST_MAP_WIDTH;
      map_height_r   <= RST_MAP_HEIGHT;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OCTAVE_TOTAL: octave_total_r <= cfg_data[3:0];
        CFG_BASE_PERIOD:  base_period_r  <= cfg_data;
        CFG_OCTAVE_GAIN:  octave_gain_r  <= cfg_data;
        CFG_FREQ_STEP:    freq_step_r    <= cfg_data;
        CFG_MAP_WIDTH:    map_width_r    <= cfg_data[6:0];
        CFG_MAP_HEIGHT:   map_height_r   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // clamp map size to 1..MAX_DIM and octave count to MAX_OCTAVES
  always_comb begin
    if (map_width_r == '0) begin
      w_c = DW'(1);
    end else if (32'(map_width_r) > MAX_DIM) begin
      w_c = DW'(MAX_DIM);
    end else begin
      w_c = DW'(map_width_r);
    end
    if (map_height_r == '0) begin
      h_c = DW'(1);
    end else if (32'(map_height_r) > MAX_DIM) begin
      h_c = DW'(MAX_DIM);
    end else begin
      h_c = DW'(map_height_r);
    end
    if (32'(octave_total_r) > MAX_OCTAVES) begin
      oct_c = OW'(MAX_OCTAVES);
    end else begin
      oct_c = OW'(octave_total_r);
    end
  end

  assign denom_c    = XW'(base_period_r) << oct_c;
  assign x0_c       = x_r - rx_r;
  assign y0_c       = y_r - ry_r;
  assign wx_c       = WTAB[ix_r];
  assign wy_c       = WTAB[iy_r];
  assign idx_full   = alu_q >> FREQ_FRAC;
  assign idx_c      = (idx_full > XW'(COS_TABLE_DEPTH)) ? IXW'(COS_TABLE_DEPTH)
                                                        : IXW'(idx_full);
  assign interp_sum = 34'(tmp_r) + 34'(alu_q[32:0]);

  // operand select for the shared unit
  always_comb begin
    alu_state      = 1'b1;
    alu_req.is_div = 1'b0;
    alu_a          = '0;
    alu_b          = '0;
    case (state_r)
      S_QMX: begin
        alu_req.is_div = 1'b1;
        alu_a = XW'(w_c);
        alu_b = XW'(px_r);
      end
      S_QMY: begin
        alu_req.is_div = 1'b1;
        alu_a = XW'(h_c);
        alu_b = XW'(py_r);
      end
      S_F0: begin
        alu_req.is_div = 1'b1;
        alu_a = denom_c;
        alu_b = FREQ_DIVIDEND;
      end
      S_P: begin
        alu_req.is_div = 1'b1;
        alu_a = XW'(freq_r);
        alu_b = FREQ_ONE;
      end
      S_RY: begin
        alu_req.is_div = 1'b1;
        alu_a = XW'(p_r);
        alu_b = XW'(y_r);
      end
      S_Y1: begin
        alu_req.is_div = 1'b1;
        alu_a = XW'(h_c);
        alu_b = XW'(y0_c) + XW'(p_r);
      end
      S_RX: begin
        alu_req.is_div = 1'b1;
        alu_a = XW'(p_r);
        alu_b = XW'(x_r);
      end
      S_X1: begin
        alu_req.is_div = 1'b1;
        alu_a = XW'(w_c);
        alu_b = XW'(x0_c) + XW'(p_r);
      end
      S_BX: begin
        alu_a = XW'(freq_r);
        alu_b = XW'(rx_r);
      end
      S_BY: begin
        alu_a = XW'(freq_r);
        alu_b = XW'(ry_r);
      end
      S_IX, S_IY: begin
        alu_a = XW'(blend_r);
        alu_b = XW'(COS_TABLE_DEPTH);
      end
      S_T1: begin
        alu_a = XW'(a00_r);
        alu_b = XW'(17'h10000 - wx_c);
      end
      S_T2: begin
        alu_a = XW'(a10_r);
        alu_b = XW'(wx_c);
      end
      S_B1: begin
        alu_a = XW'(a01_r);
        alu_b = XW'(17'h10000 - wx_c);
      end
      S_B2: begin
        alu_a = XW'(a11_r);
        alu_b = XW'(wx_c);
      end
      S_V1: begin
        alu_a = XW'(top_r);
        alu_b = XW'(17'h10000 - wy_c);
      end
      S_V2: begin
        alu_a = XW'(bot_r);
        alu_b = XW'(wy_c);
      end
      S_S: begin
        alu_a = XW'(v_r);
        alu_b = XW'(amp_r);
      end
      S_F: begin
        alu_a = XW'(freq_r);
        alu_b = XW'(freq_step_r);
      end
      S_A: begin
        alu_a = XW'(amp_r);
        alu_b = XW'(octave_gain_r);
      end
      S_DIV: begin
        alu_req.is_div = 1'b1;
        alu_a = XW'(total_r);
        alu_b = XW'(sum_r);
      end
      default: alu_state = 1'b0;
    endcase
    alu_req.start = alu_state && !issued_r;
  end

  // base map addressing: the four corners go out on consecutive cycles
  always_comb begin
    ram_we    = (state_r == S_WWR);
    ram_waddr = AW'(y_r * MAX_DIM + x_r);
    case (state_r)
      S_RB:    ram_raddr = AW'(y_r * MAX_DIM + x1_r) - AW'(ry_r * MAX_DIM);
      S_RC:    ram_raddr = AW'(y1_r * MAX_DIM + x0_c);
      S_RD:    ram_raddr = AW'(y1_r * MAX_DIM + x1_r);
      default: ram_raddr = AW'(y0_c * MAX_DIM + x0_c);
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    issued_nxt    = issued_r;
    out_valid_nxt = 1'b0;
    out_noise_nxt = out_noise_r;
    px_nxt = px_r;  py_nxt = py_r;  smp_nxt = smp_r;
    x_nxt = x_r;    y_nxt = y_r;
    rx_nxt = rx_r;  ry_nxt = ry_r;
    x1_nxt = x1_r;  y1_nxt = y1_r;
    freq_nxt = freq_r;  p_nxt = p_r;  blend_nxt = blend_r;
    ix_nxt = ix_r;  iy_nxt = iy_r;
    amp_nxt = amp_r;  sum_nxt = sum_r;  total_nxt = total_r;  k_nxt = k_r;
    a00_nxt = a00_r;  a10_nxt = a10_r;  a01_nxt = a01_r;  a11_nxt = a11_r;
    tmp_nxt = tmp_r;  top_nxt = top_r;  bot_nxt = bot_r;  v_nxt = v_r;

    if (alu_req.start) begin
      issued_nxt = 1'b1;
    end
    if (alu_done) begin
      issued_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          px_nxt    = in_pos_x;
          py_nxt    = in_pos_y;
          smp_nxt   = in_sample_value;
          state_nxt = in_op ? S_QMX : S_WMX;
        end
      end
      // write coordinates wrap at the storage size: subtract until in range
      S_WMX: begin
        if (32'(px_r) >= MAX_DIM) begin
          px_nxt = px_r - 6'(MAX_DIM);
        end else begin
          x_nxt = CW'(px_r);
          state_nxt = S_WMY;
        end
      end
      S_WMY: begin
        if (32'(py_r) >= MAX_DIM) begin
          py_nxt = py_r - 6'(MAX_DIM);
        end else begin
          y_nxt = CW'(py_r);
          state_nxt = S_WWR;
        end
      end
      S_WWR: state_nxt = S_IDLE;
      S_QMX: if (alu_done) begin
        x_nxt = CW'(alu_rem);
        state_nxt = S_QMY;
      end
      S_QMY: if (alu_done) begin
        y_nxt = CW'(alu_rem);
        state_nxt = S_INIT;
      end
      S_INIT: begin
        amp_nxt   = octave_gain_r;
        sum_nxt   = '0;
        total_nxt = '0;
        k_nxt     = '0;
        if (denom_c == '0) begin
          freq_nxt  = FREQ_W'(FREQ_ONE);
          state_nxt = S_LOOP;
        end else begin
          state_nxt = S_F0;
        end
      end
      S_F0: if (alu_done) begin
        freq_nxt = (alu_q > FREQ_ONE) ? FREQ_W'(FREQ_ONE) : FREQ_W'(alu_q);
        state_nxt = S_LOOP;
      end
      S_LOOP: begin
        if (k_r == oct_c) begin
          state_nxt = S_FIN;
        end else if (freq_r == '0) begin
          // a zero frequency gives the longest period
          p_nxt = FREQ_W'(FREQ_ONE);
          state_nxt = S_RY;
        end else begin
          state_nxt = S_P;
        end
      end
      S_P: if (alu_done) begin
        p_nxt = (alu_q == '0) ? FREQ_W'(1) : FREQ_W'(alu_q);
        state_nxt = S_RY;
      end
      S_RY: if (alu_done) begin
        ry_nxt = CW'(alu_rem);
        state_nxt = S_Y1;
      end
      S_Y1: if (alu_done) begin
        y1_nxt = CW'(alu_rem);
        state_nxt = S_RX;
      end
      S_RX: if (alu_done) begin
        rx_nxt = CW'(alu_rem);
        state_nxt = S_X1;
      end
      S_X1: if (alu_done) begin
        x1_nxt = CW'(alu_rem);
        state_nxt = S_BX;
      end
      S_BX: if (alu_done) begin
        blend_nxt = FREQ_W'(alu_q);
        state_nxt = S_IX;
      end
      S_IX: if (alu_done) begin
        ix_nxt = idx_c;
        state_nxt = S_BY;
      end
      S_BY: if (alu_done) begin
        blend_nxt = FREQ_W'(alu_q);
        state_nxt = S_IY;
      end
      S_IY: if (alu_done) begin
        iy_nxt = idx_c;
        state_nxt = S_RA;
      end
      S_RA: state_nxt = S_RB;
      S_RB: begin
        a00_nxt = ram_rdata;
        state_nxt = S_RC;
      end
      S_RC: begin
        a10_nxt = ram_rdata;
        state_nxt = S_RD;
      end
      S_RD: begin
        a01_nxt = ram_rdata;
        state_nxt = S_RE;
      end
      S_RE: begin
        a11_nxt = ram_rdata;
        state_nxt = S_T1;
      end
      S_T1: if (alu_done) begin
        tmp_nxt = alu_q[32:0];
        state_nxt = S_T2;
      end
      S_T2: if (alu_done) begin
        top_nxt = interp_sum[31:16];
        state_nxt = S_B1;
      end
      S_B1: if (alu_done) begin
        tmp_nxt = alu_q[32:0];
        state_nxt = S_B2;
      end
      S_B2: if (alu_done) begin
        bot_nxt = interp_sum[31:16];
        state_nxt = S_V1;
      end
      S_V1: if (alu_done) begin
        tmp_nxt = alu_q[32:0];
        state_nxt = S_V2;
      end
      S_V2: if (alu_done) begin
        v_nxt = interp_sum[31:16];
        state_nxt = S_S;
      end
      S_S: if (alu_done) begin
        sum_nxt   = sum_r + SUMW'(alu_q[31:0]);
        total_nxt = total_r + TOTW'(amp_r);
        state_nxt = S_F;
      end
      S_F: if (alu_done) begin
        freq_nxt = ((alu_q >> 12) > FREQ_ONE) ? FREQ_W'(FREQ_ONE)
                                               : FREQ_W'(alu_q >> 12);
        state_nxt = S_A;
      end
      S_A: if (alu_done) begin
        amp_nxt = alu_q[31:16];
        k_nxt   = k_r + 1'b1;
        state_nxt = S_LOOP;
      end
      S_FIN: begin
        if (total_r == '0) begin
          out_valid_nxt = 1'b1;
          out_noise_nxt = '0;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: if (alu_done) begin
        out_valid_nxt = 1'b1;
        out_noise_nxt = (alu_q > 64'd65535) ? 16'hFFFF : alu_q[15:0];
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_noise_r <= out_noise_nxt;
    px_r <= px_nxt;  py_r <= py_nxt;  smp_r <= smp_nxt;
    x_r <= x_nxt;    y_r <= y_nxt;
    rx_r <= rx_nxt;  ry_r <= ry_nxt;
    x1_r <= x1_nxt;  y1_r <= y1_nxt;
    freq_r <= freq_nxt;  p_r <= p_nxt;  blend_r <= blend_nxt;
    ix_r <= ix_nxt;  iy_r <= iy_nxt;
    amp_r <= amp_nxt;  sum_r <= sum_nxt;  total_r <= total_nxt;  k_r <= k_nxt;
    a00_r <= a00_nxt;  a10_r <= a10_nxt;  a01_r <= a01_nxt;  a11_r <= a11_nxt;
    tmp_r <= tmp_nxt;  top_r <= top_nxt;  bot_r <= bot_nxt;  v_r <= v_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_noise_value = out_noise_r;

endmodule

[src/fvn_ram.sv]
// generic single write port ram with registered read
module fvn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/fvn_alu.sv]
// shared shift-add multiplier and restoring divider, one bit per cycle
module fvn_alu import fvn_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  alu_req_t      req,
  input  logic [XW-1:0] opa,
  input  logic [XW-1:0] opb,
  output logic          done,
  output logic [XW-1:0] quo_prod,
  output logic [XW-1:0] rem
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic                 div_r, div_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [XW-1:0]        acc_r, acc_nxt;
  logic [XW-1:0]        mc_r, mc_nxt;
  logic [XW-1:0]        ml_r, ml_nxt;
  logic [XW-1:0]        trial;
  logic                 qbit;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    ml_nxt   = ml_r;
    trial    = {acc_r[XW-2:0], ml_r[DIV_BITS-1]};
    qbit     = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      div_nxt  = req.is_div;
      acc_nxt  = '0;
      mc_nxt   = opa;
      ml_nxt   = opb;
      cnt_nxt  = DIV_CNT_W'(DIV_BITS);
    end else if (busy_r) begin
      if (div_r) begin
        if (cnt_r == '0) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          if (trial >= mc_r) begin
            acc_nxt = trial - mc_r;
            qbit    = 1'b1;
          end else begin
            acc_nxt = trial;
          end
          ml_nxt  = {ml_r[XW-2:0], qbit};
          cnt_nxt = cnt_r - 1'b1;
        end
      end else begin
        if (ml_r == '0) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          if (ml_r[0]) begin
            acc_nxt = acc_r + mc_r;
          end
          mc_nxt = mc_r << 1;
          ml_nxt = ml_r >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    ml_r  <= ml_nxt;
  end

  assign done     = done_r;
  assign quo_prod = div_r ? (ml_r & DIV_MASK) : acc_r;
  assign rem      = acc_r;

endmodule

[tb/tb_fractal_value_noise_pixel.sv]
// testbench of the fractal value noise pixel block: directed and random commands, scoreboard
`timescale 1ns / 100ps

module tb_fractal_value_noise_pixel import fvn_pkg::*;;

  localparam int DIM = 64;
  localparam int OCT_MAX = 8;
  localparam int COS_DEPTH = 256;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam int STALL_LIMIT = 40000;
  localparam int SETTLE_CYCLES = 4;

  typedef struct {
    logic        op;
    logic [5:0]  x;
    logic [5:0]  y;
    logic [15:0] value;
  } noise_cmd_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_op;
  logic [5:0]  in_pos_x;
  logic [5:0]  in_pos_y;
  logic [15:0] in_sample_value;
  logic        out_valid;
  logic [15:0] out_noise_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  // commands waiting for the driver, and pixel values waiting for the block
  noise_cmd_t  cmd_q[$];
  logic [15:0] pixel_q[$];
  int          corner_q[$];

  // predictor copy of the block: registers, base map and weight table
  logic [3:0]  oct_reg;
  logic [15:0] period_reg;
  logic [15:0] gain_reg;
  logic [15:0] lac_reg;
  logic [6:0]  width_reg;
  logic [6:0]  height_reg;
  logic [15:0] map_mdl[DIM*DIM];
  logic [63:0] weight_tab[COS_DEPTH+1];
  // map entries that the stimulus has already filled
  bit          filled[DIM*DIM];

  int fails;
  int n_queries;
  int n_writes;
  int n_cfg;
  int n_accepted;
  int n_queued;
  int stall_cnt;

  fractal_value_noise_pixel dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_sample_value(in_sample_value),
    .out_valid      (out_valid),
    .out_noise_value(out_noise_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // sin^2 weight in q0.16 from the polynomial sine
  function automatic logic [63:0] sine_weight(logic [63:0] t);
    logic [63:0] t2, inner, mid, s, w;
    t2 = (t * t) >> 16;
    inner = 64'd42334 - ((t2 * 64'd5223) >> 16);
    mid = 64'd102944 - ((t2 * inner) >> 16);
    s = (t * mid) >> 16;
    if (s > 64'd65536) s = 64'd65536;
    w = (s * s) >> 16;
    if (w > 64'd65536) w = 64'd65536;
    return w;
  endfunction

  function automatic logic [63:0] blend_pair(logic [63:0] a, logic [63:0] b,
                                             logic [63:0] frac);
    logic [63:0] idx, w;
    idx = (frac * COS_DEPTH) >> 40;
    if (idx > COS_DEPTH) idx = COS_DEPTH;
    w = weight_tab[idx];
    return (a * (64'd65536 - w) + b * w) >> 16;
  endfunction

  function automatic int map_index(logic [63:0] x, logic [63:0] y);
    return int'((y % DIM) * DIM + (x % DIM));
  endfunction

  // fractal value at a pixel; with collect set it only lists the map entries read
  function automatic logic [15:0] fractal_pixel(logic [5:0] px, logic [5:0] py, bit collect);
    logic [63:0] w, h, x, y, oct, denom, freq, amp, acc, total, p;
    logic [63:0] x0, x1, y0, y1, bx, by, top, bot, v, res;
    w = (width_reg == 0) ? 1 : (width_reg > DIM) ? DIM : width_reg;
    h = (height_reg == 0) ? 1 : (height_reg > DIM) ? DIM : height_reg;
    x = px % w;
    y = py % h;
    oct = (oct_reg > OCT_MAX) ? OCT_MAX : oct_reg;
    denom = 64'(period_reg) << oct;
    freq = (denom == 0) ? FREQ_ONE : FREQ_DIVIDEND / denom;
    if (freq > FREQ_ONE) freq = FREQ_ONE;
    amp = gain_reg;
    acc = 0;
    total = 0;
    for (int k = 0; k < oct; k++) begin
      p = (freq == 0) ? FREQ_ONE : FREQ_ONE / freq;
      if (p == 0) p = 1;
      y0 = (y / p) * p;
      y1 = (y0 + p) % h;
      x0 = (x / p) * p;
      x1 = (x0 + p) % w;
      if (collect) begin
        corner_q.push_back(map_index(x0, y0));
        corner_q.push_back(map_index(x1, y0));
        corner_q.push_back(map_index(x0, y1));
        corner_q.push_back(map_index(x1, y1));
      end else begin
        by = (y - y0) * freq;
        bx = (x - x0) * freq;
        top = blend_pair(map_mdl[map_index(x0, y0)], map_mdl[map_index(x1, y0)], bx);
        bot = blend_pair(map_mdl[map_index(x0, y1)], map_mdl[map_index(x1, y1)], bx);
        v = blend_pair(top, bot, by);
        acc += v * amp;
        total += amp;
      end
      freq = (freq * lac_reg) >> 12;
      if (freq > FREQ_ONE) freq = FREQ_ONE;
      amp = (amp * gain_reg) >> 16;
    end
    if (total == 0) res = 0;
    else begin
      res = acc / total;
      if (res > 64'd65535) res = 64'd65535;
    end
    return res[15:0];
  endfunction

  task automatic queue_write(logic [5:0] x, logic [5:0] y, logic [15:0] value);
    noise_cmd_t c;
    c.op = OP_WRITE;
    c.x = x;
    c.y = y;
    c.value = value;
    filled[map_index(x, y)] = 1'b1;
    cmd_q.push_back(c);
    n_queued++;
  endtask

  // fill any corner the query would read that was never written, then queue it
  task automatic queue_query(logic [5:0] x, logic [5:0] y);
    noise_cmd_t c;
    corner_q.delete();
    void'(fractal_pixel(x, y, 1'b1));
    foreach (corner_q[i])
      if (!filled[corner_q[i]])
        queue_write(6'(corner_q[i] % DIM), 6'(corner_q[i] / DIM), 16'($urandom));
    c.op = OP_QUERY;
    c.x = x;
    c.y = y;
    c.value = 16'($urandom);
    cmd_q.push_back(c);
    n_queued++;
  endtask

  // block idle: nothing queued, nothing driven, nothing in flight
  task automatic wait_idle();
    do @(negedge clk);
    while (cmd_q.size() != 0 || start || busy || pixel_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_OCTAVE_TOTAL: oct_reg = data[3:0];
      CFG_BASE_PERIOD:  period_reg = data;
      CFG_OCTAVE_GAIN:  gain_reg = data;
      CFG_FREQ_STEP:    lac_reg = data;
      CFG_MAP_WIDTH:    width_reg = data[6:0];
      CFG_MAP_HEIGHT:   height_reg = data[6:0];
      default: ;
    endcase
    n_cfg++;
    stall_cnt = 0;
  endtask

  task automatic set_all(logic [3:0] o, logic [15:0] p, logic [15:0] g, logic [15:0] l,
                         logic [6:0] w, logic [6:0] h);
    wait_idle();
    write_reg(CFG_OCTAVE_TOTAL, 16'(o));
    write_reg(CFG_BASE_PERIOD, p);
    write_reg(CFG_OCTAVE_GAIN, g);
    write_reg(CFG_FREQ_STEP, l);
    write_reg(CFG_MAP_WIDTH, 16'(w));
    write_reg(CFG_MAP_HEIGHT, 16'(h));
  endtask

  function automatic logic [15:0] pick16(logic [15:0] lo);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(lo, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [6:0] pick_dim();
    case ($urandom_range(0, 3))
      0: return 7'd1;
      1: return 7'd64;
      default: return 7'($urandom_range(1, 64));
    endcase
  endfunction

  // driver: one beat per accepted command, predictor runs at acceptance
  always @(posedge clk) begin
    noise_cmd_t c;
    bit idle;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        n_accepted++;
        if (in_op == OP_WRITE) begin
          map_mdl[map_index(in_pos_x, in_pos_y)] = in_sample_value;
          n_writes++;
        end else begin
          pixel_q.push_back(fractal_pixel(in_pos_x, in_pos_y, 1'b0));
          n_queries++;
        end
      end
      if (!start || !busy) begin
        // a stretch with no idle gaps in the middle of the run
        idle = (n_accepted > 400 && n_accepted < 700) ? 1'b0 : ($urandom_range(0, 99) < 13);
        if (cmd_q.size() != 0 && !idle) begin
          c = cmd_q.pop_front();
          start <= 1'b1;
          in_op <= c.op;
          in_pos_x <= c.x;
          in_pos_y <= c.y;
          in_sample_value <= c.value;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobe beat is checked against the oldest predicted pixel
  always @(posedge clk) begin
    logic [15:0] want;
    if (rst_n && out_valid) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel beat, got %h", $realtime, out_noise_value);
        fails++;
      end else begin
        want = pixel_q.pop_front();
        if (want !== out_noise_value) begin
          $display("%0t: noise_value expected %h got %h", $realtime, want, out_noise_value);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
      stall_cnt = 0;
    else
      stall_cnt++;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("%0t: no progress, %0d pixels outstanding", $realtime, pixel_q.size());
      $display("fractal_value_noise_pixel: mismatch");
      $finish;
    end
  end

  initial begin
    int qx, qy;
    int target;
    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_WRITE;
    in_pos_x = '0;
    in_pos_y = '0;
    in_sample_value = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_OCTAVE_TOTAL;
    cfg_data = '0;
    fails = 0;
    n_queries = 0;
    n_writes = 0;
    n_cfg = 0;
    n_accepted = 0;
    n_queued = 0;
    stall_cnt = 0;
    oct_reg = RST_OCTAVE_TOTAL;
    period_reg = RST_BASE_PERIOD;
    gain_reg = RST_OCTAVE_GAIN;
    lac_reg = RST_FREQ_STEP;
    width_reg = RST_MAP_WIDTH;
    height_reg = RST_MAP_HEIGHT;
    for (int i = 0; i <= COS_DEPTH; i++)
      weight_tab[i] = sine_weight((64'(i) * 64'd65536) / COS_DEPTH);
    foreach (map_mdl[i]) map_mdl[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at reset settings: extreme samples and corner pixels
    queue_write(6'd0, 6'd0, 16'hFFFF);
    queue_write(6'd63, 6'd63, 16'h0000);
    queue_write(6'd63, 6'd0, 16'hAAAA);
    queue_write(6'd0, 6'd63, 16'h5555);
    queue_query(6'd0, 6'd0);
    queue_query(6'd63, 6'd63);
    queue_query(6'd31, 6'd17);
    queue_query(6'd1, 6'd62);

    // longest base period, steepest frequency step, max octaves, one-column map (query wraps outside)
    set_all(4'd8, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd1, 7'd64);
    queue_query(6'd63, 6'd5);
    queue_query(6'd0, 6'd63);
    queue_write(6'd0, 6'd5, 16'h8001);
    queue_query(6'd40, 6'd5);

    // zero gain gives zero total amplitude; one-row map, slowest lacunarity
    set_all(4'd1, 16'd256, 16'd0, 16'd4096, 7'd64, 7'd1);
    queue_query(6'd12, 6'd50);
    queue_query(6'd63, 6'd63);

    // long steady periods: slow start frequency held by unit lacunarity over many octaves
    set_all(4'd8, 16'd256, 16'd32768, 16'd4096, 7'd64, 7'd64);
    queue_query(6'd45, 6'd33);
    queue_query(6'd7, 6'd60);

    // random phases, each about 75 commands including corner fills
    for (int ph = 0; ph < 12; ph++) begin
      set_all(($urandom_range(0, 4) == 0) ? 4'd8 : 4'($urandom_range(1, 3)),
              pick16(16'd256), pick16(16'd0), pick16(16'd4096), pick_dim(), pick_dim());
      target = n_queued + 75;
      while (n_queued < target) begin
        qx = $urandom_range(0, 63);
        qy = $urandom_range(0, 63);
        if ($urandom_range(0, 99) < 40)
          queue_write(6'(qx), 6'(qy), 16'($urandom));
        else
          queue_query(6'(qx), 6'(qy));
      end
    end

    wait_idle();
    $display("covered %0d queries and %0d sample writes over %0d register writes",
             n_queries, n_writes, n_cfg);
    if (fails == 0)
      $display("fractal_value_noise_pixel: match");
    else
      $display("fractal_value_noise_pixel: mismatch");
    $finish;
  end

endmodule

[sim.f]
src/fvn_pkg.sv
src/fvn_ram.sv
src/fvn_alu.sv
src/fractal_value_noise_pixel.sv
tb/tb_fractal_value_noise_pixel.sv
